// File: rtl/cplt_pkg.sv
// Shared types, constants and command codes for the piecewise-linear tracker.
package cplt_pkg;

    localparam int HeapDepth = 1024;
    localparam int IdxW      = $clog2(HeapDepth);
    localparam int CntW      = $clog2(HeapDepth + 1);
    localparam int PtW       = 48;
    localparam int ValW      = 64;
    localparam int OpW       = 32;

    localparam logic [2:0] FUNC_ADD_R   = 3'd0;
    localparam logic [2:0] FUNC_ADD_L   = 3'd1;
    localparam logic [2:0] FUNC_ADD_ABS = 3'd2;
    localparam logic [2:0] FUNC_PREFIX  = 3'd3;
    localparam logic [2:0] FUNC_SUFFIX  = 3'd4;
    localparam logic [2:0] FUNC_SLIDE   = 3'd5;
    localparam logic [2:0] FUNC_SHIFT   = 3'd6;
    localparam logic [2:0] FUNC_EVAL    = 3'd7;

    // Datapath commands issued by the controller.
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_LOAD      = 4'd1;  // latch request fields
    localparam logic [3:0] CMD_RD_TOP    = 4'd2;  // read top of the other heap
    localparam logic [3:0] CMD_PIECE     = 4'd3;  // min update, decide replace
    localparam logic [3:0] CMD_RD_KIDS   = 4'd4;  // read children of cursor
    localparam logic [3:0] CMD_SIFT_DN   = 4'd5;  // compare children, swap
    localparam logic [3:0] CMD_PUSH_INIT = 4'd6;  // write new leaf
    localparam logic [3:0] CMD_RD_PAR    = 4'd7;  // read parent of cursor
    localparam logic [3:0] CMD_SIFT_UP   = 4'd8;  // compare parent, swap
    localparam logic [3:0] CMD_EV_INIT   = 4'd9;
    localparam logic [3:0] CMD_EV_STEP   = 4'd10;
    localparam logic [3:0] CMD_MISC      = 4'd11; // clear, slide, shift
    localparam logic [3:0] CMD_RD_TOPS   = 4'd12; // read both tops for result
    localparam logic [3:0] CMD_RESULT    = 4'd13;

    typedef struct packed {
        logic [3:0] cmd;
        logic       side;   // 0 works on left heap, 1 on right heap
    } cplt_ctrl_t;

    typedef struct packed {
        logic replace;      // piece step moved the top
        logic down_done;    // sift-down finished
        logic up_done;      // sift-up finished
        logic ev_done;      // evaluation walk finished
        logic lfull;
        logic rfull;
        logic rempty_side;  // selected other heap is empty
    } cplt_stat_t;

endpackage

// File: rtl/cplt_if.sv
// Valid/ready channel interfaces for requests and results.
interface cplt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] operand;
    modport source (output valid, output func, output operand, input ready);
    modport sink   (input valid, input func, input operand, output ready);
endinterface

interface cplt_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] min_value;
    logic [47:0] left_point;
    logic [47:0] right_point;
    logic        left_empty;
    logic        right_empty;
    logic [63:0] eval_value;
    logic        full_error;
    modport source (output valid, output min_value, output left_point,
                    output right_point, output left_empty, output right_empty,
                    output eval_value, output full_error, input ready);
    modport sink   (input valid, input min_value, input left_point,
                    input right_point, input left_empty, input right_empty,
                    input eval_value, input full_error, output ready);
endinterface

// File: rtl/cplt_ctrl.sv
// Controller state machine sequencing heap and evaluation steps.
module cplt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [2:0]          req_func,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output cplt_pkg::cplt_ctrl_t ctrl,
    input  cplt_pkg::cplt_stat_t stat
);
    import cplt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_RDTOP  = 4'd2;
    localparam logic [3:0] S_PIECE  = 4'd3;
    localparam logic [3:0] S_RDKID  = 4'd4;
    localparam logic [3:0] S_SDOWN  = 4'd5;
    localparam logic [3:0] S_PUSH   = 4'd6;
    localparam logic [3:0] S_RDPAR  = 4'd7;
    localparam logic [3:0] S_SUP    = 4'd8;
    localparam logic [3:0] S_EVINIT = 4'd9;
    localparam logic [3:0] S_EVSTEP = 4'd10;
    localparam logic [3:0] S_RDTOPS = 4'd11;
    localparam logic [3:0] S_RES    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [2:0] func_reg, func_next;
    logic       side_reg, side_next;   // heap being pushed into
    logic       second_reg, second_next; // abs: second piece pending
    logic       err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            func_reg   <= FUNC_ADD_R;
            side_reg   <= 1'b0;
            second_reg <= 1'b0;
            err_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            func_reg   <= func_next;
            side_reg   <= side_next;
            second_reg <= second_next;
            err_reg    <= err_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        side_next   = side_reg;
        second_next = second_reg;
        err_next    = err_reg;
        ctrl.cmd    = CMD_NONE;
        ctrl.side   = side_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.cmd   = CMD_LOAD;
                    func_next  = req_func;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                err_next    = 1'b0;
                second_next = 1'b0;
                priority case (func_reg)
                    FUNC_ADD_R:
                    begin
                        side_next = 1'b1;
                        if (stat.rfull)
                        begin
                            err_next   = 1'b1;
                            state_next = S_RDTOPS;
                        end
                        else
                            state_next = S_RDTOP;
                    end
                    FUNC_ADD_L:
                    begin
                        side_next = 1'b0;
                        if (stat.lfull)
                        begin
                            err_next   = 1'b1;
                            state_next = S_RDTOPS;
                        end
                        else
                            state_next = S_RDTOP;
                    end
                    FUNC_ADD_ABS:
                    begin
                        side_next = 1'b1;
                        if (stat.lfull || stat.rfull)
                        begin
                            err_next   = 1'b1;
                            state_next = S_RDTOPS;
                        end
                        else
                        begin
                            second_next = 1'b1;
                            state_next  = S_RDTOP;
                        end
                    end
                    FUNC_EVAL:
                        state_next = S_EVINIT;
                    default:
                    begin
                        ctrl.cmd   = CMD_MISC;
                        state_next = S_RDTOPS;
                    end
                endcase
            end
            S_RDTOP:
            begin
                ctrl.cmd   = CMD_RD_TOP;
                state_next = S_PIECE;
            end
            S_PIECE:
            begin
                ctrl.cmd   = CMD_PIECE;
                state_next = stat.replace ? S_RDKID : S_PUSH;
            end
            S_RDKID:
            begin
                ctrl.cmd   = CMD_RD_KIDS;
                ctrl.side  = ~side_reg;
                state_next = S_SDOWN;
            end
            S_SDOWN:
            begin
                ctrl.cmd   = CMD_SIFT_DN;
                ctrl.side  = ~side_reg;
                state_next = stat.down_done ? S_PUSH : S_RDKID;
            end
            S_PUSH:
            begin
                ctrl.cmd   = CMD_PUSH_INIT;
                state_next = S_RDPAR;
            end
            S_RDPAR:
            begin
                ctrl.cmd   = CMD_RD_PAR;
                state_next = S_SUP;
            end
            S_SUP:
            begin
                ctrl.cmd   = CMD_SIFT_UP;
                state_next = S_RDPAR;
                if (stat.up_done)
                begin
                    state_next = S_RDTOPS;
                    if (second_reg)
                    begin
                        second_next = 1'b0;
                        side_next   = 1'b0;
                        state_next  = S_RDTOP;
                    end
                end
            end
            S_EVINIT:
            begin
                ctrl.cmd   = CMD_EV_INIT;
                state_next = S_EVSTEP;
            end
            S_EVSTEP:
            begin
                ctrl.cmd = CMD_EV_STEP;
                if (stat.ev_done)
                    state_next = S_RDTOPS;
            end
            S_RDTOPS:
            begin
                ctrl.cmd   = CMD_RD_TOPS;
                state_next = S_RES;
            end
            S_RES:
            begin
                ctrl.cmd   = CMD_RESULT;
                ctrl.side  = err_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_DISP))
        else $error("accepted request did not reach dispatch");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request and result sides open together");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result dropped while stalled");
endmodule

// File: rtl/cplt_dp.sv
// Datapath: heap memories, offsets, running minimum and evaluation walk.
module cplt_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           req_func,
    input  logic [31:0]          req_operand,
    input  cplt_pkg::cplt_ctrl_t ctrl,
    output cplt_pkg::cplt_stat_t stat,
    output logic [63:0]          min_value,
    output logic [47:0]          left_point,
    output logic [47:0]          right_point,
    output logic                 left_empty,
    output logic                 right_empty,
    output logic [63:0]          eval_value,
    output logic                 full_error
);
    import cplt_pkg::*;

    logic [PtW-1:0] lmem [HeapDepth];
    logic [PtW-1:0] rmem [HeapDepth];

    logic [CntW-1:0] lcnt_reg, rcnt_reg;
    logic [ValW-1:0] min_reg;
    logic [PtW-1:0]  loff_reg, roff_reg;
    logic [2:0]      func_reg;
    logic [PtW-1:0]  a_reg;
    logic [PtW-1:0]  val_reg;      // value sifting (stored form)
    logic [PtW-1:0]  moved_reg;    // absolute value to push
    logic [CntW-1:0] cur_reg;      // cursor index
    logic [CntW-1:0] n_reg;        // live count of heap being sifted
    logic [ValW-1:0] ev_reg;
    logic [CntW-1:0] ei_reg;
    logic            eph_reg;      // eval phase: 0 left, 1 right

    // Memory ports: two read ports per heap, registered.
    logic [IdxW-1:0] la0, la1, ra0, ra1;
    logic [PtW-1:0]  lq0, lq1, rq0, rq1;
    logic            lwe, rwe;
    logic [IdxW-1:0] lwa, rwa;
    logic [PtW-1:0]  lwd, rwd;
    logic            lwe2, rwe2;
    logic [IdxW-1:0] lwa2, rwa2;
    logic [PtW-1:0]  lwd2, rwd2;

    always_ff @(posedge clk)
    begin
        if (lwe)
            lmem[lwa] <= lwd;
        if (lwe2)
            lmem[lwa2] <= lwd2;
        if (rwe)
            rmem[rwa] <= rwd;
        if (rwe2)
            rmem[rwa2] <= rwd2;
        lq0 <= lmem[la0];
        lq1 <= lmem[la1];
        rq0 <= rmem[ra0];
        rq1 <= rmem[ra1];
    end

    function automatic logic prio(input logic [PtW-1:0] x, input logic [PtW-1:0] y,
                                  input logic mx);
        prio = mx ? ($signed(x) > $signed(y)) : ($signed(x) < $signed(y));
    endfunction

    function automatic logic [ValW-1:0] pos_diff(input logic [PtW-1:0] p,
                                                 input logic [PtW-1:0] q);
        logic signed [ValW-1:0] d;
        d = ValW'($signed(p)) - ValW'($signed(q));
        pos_diff = (d > 0) ? d : '0;
    endfunction

    // Side-selected views. side 0 = left (max) heap, 1 = right (min) heap.
    wire             sd     = ctrl.side;
    wire [PtW-1:0]   off_s  = sd ? roff_reg : loff_reg;     // target heap
    wire [PtW-1:0]   off_o  = sd ? loff_reg : roff_reg;     // other heap
    wire [CntW-1:0]  cnt_s  = sd ? rcnt_reg : lcnt_reg;
    wire [CntW-1:0]  cnt_o  = sd ? lcnt_reg : rcnt_reg;
    wire [PtW-1:0]   q0_s   = sd ? rq0 : lq0;
    wire [PtW-1:0]   q1_s   = sd ? rq1 : lq1;
    wire [PtW-1:0]   q0_o   = sd ? lq0 : rq0;
    wire             mx_s   = ~sd;

    wire [CntW:0]    kid_l  = {cur_reg, 1'b1};
    wire [CntW:0]    kid_r  = kid_l + 1'b1;
    wire [CntW-1:0]  parent = (cur_reg - 1'b1) >> 1;
    wire [IdxW-1:0]  cur_ix = cur_reg[IdxW-1:0];

    logic [PtW-1:0]  top_pt, sa;
    logic            kl_ok, kr_ok, pick_l, pick_r;
    logic [PtW-1:0]  ev_x;

    always_comb
    begin
        top_pt = q0_o + off_o;
        sa     = a_reg - off_o;
        kl_ok  = (kid_l < {1'b0, n_reg});
        kr_ok  = (kid_r < {1'b0, n_reg});
        pick_l = 1'b0;
        pick_r = 1'b0;
        if (kl_ok && prio(q0_s, val_reg, mx_s))
        begin
            pick_l = 1'b1;
            if (kr_ok && prio(q1_s, q0_s, mx_s))
            begin
                pick_l = 1'b0;
                pick_r = 1'b1;
            end
        end
        else if (kr_ok && prio(q1_s, val_reg, mx_s))
            pick_r = 1'b1;
        ev_x = eph_reg ? (rq0 + roff_reg) : (lq0 + loff_reg);
    end

    // Read addresses.
    always_comb
    begin
        la0 = '0;
        la1 = '0;
        ra0 = '0;
        ra1 = '0;
        unique case (ctrl.cmd)
            CMD_RD_KIDS:
            begin
                la0 = kid_l[IdxW-1:0];
                la1 = kid_r[IdxW-1:0];
                ra0 = kid_l[IdxW-1:0];
                ra1 = kid_r[IdxW-1:0];
            end
            CMD_RD_PAR:
            begin
                la0 = parent[IdxW-1:0];
                ra0 = parent[IdxW-1:0];
            end
            CMD_EV_STEP:
            begin
                la0 = ei_reg[IdxW-1:0] + 1'b1;
                ra0 = ei_reg[IdxW-1:0] + 1'b1;
                if (!eph_reg && (ei_reg + 1'b1 >= lcnt_reg))
                    la0 = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Writes.
    always_comb
    begin
        lwe = 1'b0; rwe = 1'b0; lwe2 = 1'b0; rwe2 = 1'b0;
        lwa = cur_ix; rwa = cur_ix; lwa2 = cur_ix; rwa2 = cur_ix;
        lwd = val_reg; rwd = val_reg; lwd2 = val_reg; rwd2 = val_reg;
        unique case (ctrl.cmd)
            CMD_SIFT_DN:
            begin
                if (pick_l || pick_r)
                begin
                    lwe = ~sd; rwe = sd;
                    lwd = pick_l ? q0_s : q1_s;
                    rwd = lwd;
                    lwe2 = ~sd; rwe2 = sd;
                    lwa2 = pick_l ? kid_l[IdxW-1:0] : kid_r[IdxW-1:0];
                    rwa2 = lwa2;
                end
                else
                begin
                    lwe = ~sd; rwe = sd;
                end
            end
            CMD_PUSH_INIT:
            begin
                lwe = ~sd; rwe = sd;
                lwa = cnt_s[IdxW-1:0]; rwa = cnt_s[IdxW-1:0];
                lwd = moved_reg - off_s; rwd = lwd;
            end
            CMD_SIFT_UP:
            begin
                if (!stat.up_done)
                begin
                    lwe = ~sd; rwe = sd;
                    lwd = q0_s; rwd = q0_s;
                    lwe2 = ~sd; rwe2 = sd;
                    lwa2 = parent[IdxW-1:0]; rwa2 = lwa2;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The top of the other heap is compared with its own ordering.
    always_comb
    begin
        stat.replace     = (cnt_o != '0) && prio(q0_o, sa, sd);
        stat.down_done   = ~(pick_l || pick_r);
        stat.up_done     = (cur_reg == '0) || ~prio(val_reg, q0_s, mx_s);
        stat.ev_done     = eph_reg ? (ei_reg + 1'b1 >= rcnt_reg) : 1'b0;
        stat.lfull       = (lcnt_reg >= CntW'(HeapDepth));
        stat.rfull       = (rcnt_reg >= CntW'(HeapDepth));
        stat.rempty_side = (cnt_o == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcnt_reg <= '0;
            rcnt_reg <= '0;
            min_reg  <= '0;
            loff_reg <= '0;
            roff_reg <= '0;
        end
        else
        begin
            unique case (ctrl.cmd)
                CMD_PIECE:
                begin
                    if (!stat.rempty_side)
                        min_reg <= min_reg + (sd ? pos_diff(top_pt, a_reg)
                                                 : pos_diff(a_reg, top_pt));
                end
                CMD_PUSH_INIT:
                begin
                    if (sd)
                        rcnt_reg <= rcnt_reg + 1'b1;
                    else
                        lcnt_reg <= lcnt_reg + 1'b1;
                end
                CMD_MISC:
                begin
                    priority case (func_reg)
                        FUNC_PREFIX: rcnt_reg <= '0;
                        FUNC_SUFFIX: lcnt_reg <= '0;
                        FUNC_SLIDE:
                        begin
                            if ($signed(a_reg) > 0)
                                roff_reg <= roff_reg + a_reg;
                            else
                                loff_reg <= loff_reg + a_reg;
                        end
                        default:
                        begin
                            loff_reg <= loff_reg + a_reg;
                            roff_reg <= roff_reg + a_reg;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            CMD_LOAD:
            begin
                func_reg <= req_func;
                a_reg    <= PtW'($signed(req_operand));
                ev_reg   <= '0;
            end
            CMD_PIECE:
            begin
                moved_reg <= stat.replace ? top_pt : a_reg;
                if (stat.replace)
                begin
                    val_reg   <= sa;
                    cur_reg   <= '0;
                    n_reg     <= cnt_o;
                end
            end
            CMD_SIFT_DN:
            begin
                if (pick_l)
                    cur_reg <= kid_l[CntW-1:0];
                else if (pick_r)
                    cur_reg <= kid_r[CntW-1:0];
            end
            CMD_PUSH_INIT:
            begin
                val_reg <= moved_reg - off_s;
                cur_reg <= cnt_s;
            end
            CMD_SIFT_UP:
            begin
                if (!stat.up_done)
                    cur_reg <= parent;
            end
            CMD_EV_INIT:
            begin
                ev_reg  <= min_reg;
                ei_reg  <= '1;
                eph_reg <= (lcnt_reg == '0);
            end
            CMD_EV_STEP:
            begin
                if ((eph_reg ? rcnt_reg : lcnt_reg) != '0 && ei_reg != '1)
                    ev_reg <= ev_reg + (eph_reg ? pos_diff(a_reg, ev_x)
                                                : pos_diff(ev_x, a_reg));
                if (!eph_reg && (ei_reg + 1'b1 >= lcnt_reg) && ei_reg != '1)
                begin
                    eph_reg <= 1'b1;
                    ei_reg  <= '1;
                end
                else
                    ei_reg <= ei_reg + 1'b1;
            end
            CMD_RESULT:
            begin
                min_value   <= min_reg;
                left_empty  <= (lcnt_reg == '0);
                right_empty <= (rcnt_reg == '0);
                left_point  <= (lcnt_reg == '0) ? {1'b1, {(PtW-1){1'b0}}}
                                                : lq0 + loff_reg;
                right_point <= (rcnt_reg == '0) ? {1'b0, {(PtW-1){1'b1}}}
                                                : rq0 + roff_reg;
                eval_value  <= (func_reg == FUNC_EVAL) ? ev_reg : '0;
                full_error  <= ctrl.side;
            end
            default:
            begin
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (lcnt_reg <= CntW'(HeapDepth)) && (rcnt_reg <= CntW'(HeapDepth)))
        else $error("heap count past depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cmd == CMD_PUSH_INIT) |-> (cnt_s < CntW'(HeapDepth)))
        else $error("push into full heap");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cmd == CMD_SIFT_UP && !stat.up_done) |-> (cur_reg != '0))
        else $error("sift-up past the root");
endmodule

// File: rtl/convex_piecewise_linear_tracker_top.sv
// Top level of the convex piecewise-linear function tracker.
//
// The block holds a convex piecewise-linear function as a max-heap of left
// breakpoints and a min-heap of right breakpoints, each in its own 1024-entry
// memory with a lazy offset, plus the running minimum. One request is handled
// at a time. Clear, slide and shift requests, and an add that finds its heap
// full, go from dispatch straight to reading both tops and the result.
// An add request reads the top of the other heap and does the piece step; if
// that top is replaced, the new top is sifted down in the other heap, and then
// the new leaf is pushed into its own heap and sifted up, each sift step a
// read followed by a compare and swap. An absolute-value add runs the piece
// and sift steps twice. An evaluate request walks both heaps one entry a
// cycle. A result stays posted until the consumer takes it, and the next
// request is accepted in the cycle after that. No clearing pass is needed
// after reset: the heaps are read only below their live counts.
module convex_piecewise_linear_tracker_top (
    input  logic      clk,
    input  logic      rst_n,
    cplt_req_if.sink  req,
    cplt_rsp_if.source rsp
);
    import cplt_pkg::*;

    cplt_ctrl_t ctrl;
    cplt_stat_t stat;

    // The controller owns the handshakes; the datapath does the arithmetic.
    cplt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    cplt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_func    (req.func),
        .req_operand (req.operand),
        .ctrl        (ctrl),
        .stat        (stat),
        .min_value   (rsp.min_value),
        .left_point  (rsp.left_point),
        .right_point (rsp.right_point),
        .left_empty  (rsp.left_empty),
        .right_empty (rsp.right_empty),
        .eval_value  (rsp.eval_value),
        .full_error  (rsp.full_error)
    );
endmodule
